/* rtl/hcbp_pkg.sv */
// shared types and constants of the huffman code bit packer
package hcbp_pkg;

  // width of a stored code word and of its length field
  localparam int unsigned CodeW = 32;
  localparam int unsigned LenW  = 6;

  // width of the bit stream formed from held bits and one code word
  localparam int unsigned StreamW = CodeW + 8;

  // request kinds carried on tuser
  typedef enum logic {
    KindLoad   = 1'b0,
    KindEncode = 1'b1
  } kind_e;

  // one code table entry
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } entry_t;

endpackage

/* rtl/huffman_code_bit_packer_core.sv */
// huffman encoder bit packer: code table memory, bit accumulator and byte emitter
//
// Load requests (tuser = 0) write one symbol's code word and length into a code
// table held in a synchronous memory; the table reads as zero length after reset
// through one valid flop per entry, so no clearing pass is needed. Encode requests
// (tuser = 1) read their symbol's entry into a register at acceptance, merge the
// code with the bits held in the 8-bit accumulator and emit every completed byte,
// earliest code bit in bit 7, one byte per cycle on the master side while it is
// ready. A full byte leaves only when the next code bit arrives, and the trailing
// partial byte is never flushed. A request is accepted every cycle as long as the
// byte emitter keeps up: an encode request yields 0 to 4 bytes, and one that yields
// bytes waits in the merge stage until the emit stage is empty or is sending its
// last byte, so the sustained rate is set by the single-byte result channel. The
// first byte passes the table read register, the emit stage and the output register
// in turn, and the emit and output steps wait on back-pressure.
// Unloaded or out-of-range symbols emit nothing and leave the accumulator unchanged.
module huffman_code_bit_packer_core
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  logic [47:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int IdxW      = $clog2(SYMBOL_COUNT);
  localparam int LenCapInt = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;
  localparam logic [LenW-1:0]  LenCap  = LenW'(LenCapInt);
  localparam logic [CodeW-1:0] CodeOne = '1;
  localparam logic [7:0]       ByteOne = '1;

  // request fields
  logic [7:0]      in_symbol;
  logic [CodeW-1:0] in_code;
  logic [LenW-1:0] in_len;
  kind_e           in_kind;
  logic            in_fire;
  logic            in_range;
  logic [IdxW-1:0] in_idx;

  assign in_symbol = s_axis_tdata[7:0];
  assign in_code   = s_axis_tdata[39:8];
  assign in_len    = s_axis_tdata[45:40];
  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_range  = {24'd0, in_symbol} < 32'(SYMBOL_COUNT);
  assign in_idx    = in_symbol[IdxW-1:0];

  // load entry: length saturated, code masked to length
  logic [LenW-1:0] ld_len;
  entry_t          ld_entry;
  logic            ld_we;
  logic            rd_en;

  assign ld_len        = (in_len > LenCap) ? LenCap : in_len;
  assign ld_entry.len  = ld_len;
  assign ld_entry.code = in_code & ~(CodeOne << ld_len);
  assign ld_we         = in_fire && (in_kind == KindLoad) && in_range;
  assign rd_en         = in_fire && (in_kind == KindEncode);

  // code table memory with registered read
  entry_t mem [SYMBOL_COUNT];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      mem[in_idx] <= ld_entry;
    end
    if (rd_en) begin
      rd_q <= mem[in_idx];
    end
  end

  // per-entry valid flops, cleared at reset
  logic [SYMBOL_COUNT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ld_we) begin
      vld_q[in_idx] <= 1'b1;
    end
  end

  // merge stage state
  logic s1_valid_q;
  logic s1_hit_q;
  logic s1_fire;

  // accumulator state
  logic [7:0] acc_q, acc_d;
  logic [3:0] held_q, held_d;

  // emit stage state
  logic [StreamW-1:0] s2_s_q;
  logic [LenW-1:0]    s2_sh_q;
  logic [2:0]         s2_cnt_q;
  logic               s2_emit;
  logic               s2_free;

  // output register
  logic       out_v_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  // stream merge of held bits and looked-up code
  logic [LenW-1:0]    s1_len;
  logic [StreamW-1:0] s1_s;
  logic [6:0]         s1_t;
  logic [6:0]         s1_tm1;
  logic [2:0]         s1_n;
  logic [3:0]         s1_r;
  logic [LenW-1:0]    s1_sh;

  always_comb begin
    s1_len = s1_hit_q ? rd_q.len : '0;
    s1_s   = ({32'd0, acc_q} << s1_len) | {8'd0, rd_q.code};
    s1_t   = 7'(held_q) + 7'(s1_len);
    s1_tm1 = s1_t - 7'd1;
    s1_n   = (s1_len == '0) ? 3'd0 : s1_tm1[5:3];
    s1_r   = {1'b0, s1_tm1[2:0]} + 4'd1;
    s1_sh  = LenW'(s1_t - 7'd8);
    if (s1_len == '0) begin
      acc_d  = acc_q;
      held_d = held_q;
    end else begin
      acc_d  = s1_s[7:0] & ~(ByteOne << s1_r);
      held_d = s1_r;
    end
  end

  // handshake and stage advance
  assign s2_emit       = (s2_cnt_q != '0) && (!out_v_q || m_axis_tready);
  assign s2_free       = (s2_cnt_q == '0) || ((s2_cnt_q == 3'd1) && s2_emit);
  assign s1_fire       = s1_valid_q && ((s1_n == '0) || s2_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
      held_q     <= '0;
      s2_cnt_q   <= '0;
      out_v_q    <= 1'b0;
    end else begin
      if (rd_en) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        acc_q  <= acc_d;
        held_q <= held_d;
      end
      if (s1_fire && (s1_n != '0)) begin
        s2_cnt_q <= s1_n;
      end else if (s2_emit) begin
        s2_cnt_q <= s2_cnt_q - 3'd1;
      end
      if (s2_emit) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_hit_q <= vld_q[in_idx] && in_range;
    end
    if (s1_fire && (s1_n != '0)) begin
      s2_s_q  <= s1_s;
      s2_sh_q <= s1_sh;
    end else if (s2_emit) begin
      s2_sh_q <= s2_sh_q - LenW'(8);
    end
    if (s2_emit) begin
      out_byte_q <= 8'(s2_s_q >> s2_sh_q);
      out_last_q <= (s2_cnt_q == 3'd1);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // accumulator never holds more than one byte
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 4'd8)
    else $error("bit count above one byte");

  // at most four bytes per encode request
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_cnt_q <= 3'd4)
    else $error("emit count above four");

  // a new result only comes from a pending byte
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s2_cnt_q) != 3'd0)
    else $error("result without pending byte");

  // a merged request with bytes only moves on when the emitter can take it
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_n != 3'd0) && (s2_cnt_q != 3'd0)) |-> s2_emit)
    else $error("emit stage overrun");

endmodule

/* tb/sv/tb_huffman_code_bit_packer_core.sv */
// self-checking testbench for the huffman code bit packer core
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_core
  import hcbp_pkg::*;
;

  localparam int MaxCodeLen   = 32;
  localparam int SymbolCount  = 256;
  localparam int RandomCount  = 340;
  localparam int DrainCycles  = 20;
  localparam int CycleLimit   = 400000;

  // one request as queued for the driver
  typedef struct {
    kind_e       kind;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
    int          gap;
    bit          drain;
  } request_t;

  // one expected byte on the result side
  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  logic [47:0] s_axis_tdata = '0;
  // [0] kind
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] out_byte
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  huffman_code_bit_packer_core #(
    .MAX_CODE_LEN(MaxCodeLen),
    .SYMBOL_COUNT(SymbolCount)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // packer model state
  logic [31:0] code_word_tbl [SymbolCount] = '{default: '0};
  logic [5:0]  code_len_tbl  [SymbolCount] = '{default: '0};
  logic [7:0]  pack_acc = 8'h00;
  int unsigned pack_held = 0;

  request_t    request_q [$];
  byte_exp_t   expected_bytes [$];
  request_t    next_req;
  int          gap_left;
  int          stall_left;
  int          roll;
  int unsigned cycle_cnt = 0;
  int          n_loads = 0;
  int          n_encodes = 0;
  int          n_bytes = 0;
  int          n_errors = 0;

  // update the model with one accepted request and queue the bytes it yields
  function automatic void pack_request(input logic kind, input logic [47:0] data);
    logic [7:0]  sym;
    logic [31:0] word;
    int unsigned nbits;
    int unsigned cap;
    int unsigned i;
    int unsigned n_done;
    logic [7:0]  done_bytes [4];
    byte_exp_t   e;
    sym    = data[7:0];
    word   = data[39:8];
    nbits  = 32'(data[45:40]);
    cap    = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
    n_done = 0;
    if (kind == KindLoad) begin
      n_loads++;
      if (32'(sym) >= SymbolCount) return;
      if (nbits > cap) nbits = cap;
      if (nbits < CodeW) word = word & ((32'h1 << nbits) - 32'h1);
      code_word_tbl[sym] = word;
      code_len_tbl[sym]  = nbits[5:0];
      return;
    end
    n_encodes++;
    if (32'(sym) >= SymbolCount) return;
    word  = code_word_tbl[sym];
    nbits = 32'(code_len_tbl[sym]);
    if (nbits > CodeW) nbits = CodeW;
    // a full accumulator leaves only when the next code bit shows up
    for (i = 0; i < nbits; i++) begin
      if (pack_held >= 8) begin
        if (n_done < 4) begin
          done_bytes[n_done] = pack_acc;
          n_done++;
        end
        pack_acc  = 8'h00;
        pack_held = 0;
      end
      pack_acc = {pack_acc[6:0], word[nbits-1-i]};
      pack_held++;
    end
    for (i = 0; i < n_done; i++) begin
      e.data = done_bytes[i];
      e.last = (i == n_done - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  task automatic add_request(input kind_e kind, input logic [7:0] sym,
                             input logic [31:0] code, input logic [5:0] len,
                             input bit drain);
    request_t r;
    r.kind  = kind;
    r.sym   = sym;
    r.code  = code;
    r.len   = len;
    r.drain = drain;
    r.gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    request_q.push_back(r);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && (s_axis_tvalid || expected_bytes.size() != 0))) begin
        next_req      = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_req.kind;
        s_axis_tdata  <= {2'b00, next_req.len, next_req.code, next_req.sym};
        gap_left      <= next_req.gap;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure, with stall-free stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (cycle_cnt[9] || roll >= 20) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left    <= (roll < 17) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // monitor: check bytes against the model, then predict newly accepted requests
  always @(posedge clk_i) begin
    byte_exp_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_bytes++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: out_byte %02h last %0b", m_axis_tdata, m_axis_tlast);
          n_errors++;
        end else begin
          e = expected_bytes.pop_front();
          if (m_axis_tdata !== e.data) begin
            $error("out_byte: expected %02h actual %02h", e.data, m_axis_tdata);
            n_errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last: expected %0b actual %0b", e.last, m_axis_tlast);
            n_errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) pack_request(s_axis_tuser, s_axis_tdata);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL huffman_code_bit_packer_core");
      $finish;
    end
  end

  initial begin
    request_t    r;
    int          n;
    int          pick;
    logic [7:0]  loaded [$];

    // directed: unloaded symbol, full-width codes, masking, saturation, reloads
    add_request(KindEncode, 8'd0,   32'hDEAD_BEEF, 6'd63, 1'b0);
    add_request(KindLoad,   8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_request(KindEncode, 8'd255, 32'h0000_0000, 6'd0,  1'b0);
    add_request(KindEncode, 8'd255, 32'hFFFF_FFFF, 6'd63, 1'b0);
    add_request(KindLoad,   8'd0,   32'h0000_0000, 6'd1,  1'b0);
    add_request(KindEncode, 8'd0,   32'h0000_0000, 6'd0,  1'b0);
    add_request(KindLoad,   8'd128, 32'hFFFF_FFF5, 6'd3,  1'b0);
    add_request(KindEncode, 8'd128, 32'h0000_0000, 6'd0,  1'b0);
    add_request(KindLoad,   8'd1,   32'hFFFF_FFFF, 6'd63, 1'b0);
    add_request(KindEncode, 8'd1,   32'h0000_0000, 6'd0,  1'b0);
    add_request(KindLoad,   8'd2,   32'h1234_5678, 6'd0,  1'b0);
    add_request(KindEncode, 8'd2,   32'h0000_0000, 6'd0,  1'b0);
    add_request(KindLoad,   8'd255, 32'hA5A5_A5A5, 6'd33, 1'b0);
    add_request(KindEncode, 8'd255, 32'h0000_0000, 6'd0,  1'b0);
    add_request(KindEncode, 8'd200, 32'h0000_0000, 6'd0,  1'b0);
    add_request(KindLoad,   8'd3,   32'h0000_0000, 6'd32, 1'b0);
    add_request(KindEncode, 8'd3,   32'h0000_0000, 6'd0,  1'b0);
    add_request(KindLoad,   8'd0,   32'hFFFF_FFAA, 6'd8,  1'b0);
    add_request(KindEncode, 8'd0,   32'h0000_0000, 6'd0,  1'b0);
    add_request(KindEncode, 8'd0,   32'h0000_0000, 6'd0,  1'b0);
    add_request(KindLoad,   8'd77,  32'h0000_0001, 6'd1,  1'b0);
    add_request(KindEncode, 8'd77,  32'h0000_0000, 6'd0,  1'b0);
    loaded = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd3, 8'd77};

    // random: mostly encodes of loaded symbols, with loads mixed in
    for (n = 0; n < RandomCount; n++) begin
      r.code  = $urandom;
      r.drain = (n == 0) || (n == RandomCount / 2);
      if ($urandom_range(0, 99) < 30) begin
        r.kind = KindLoad;
        r.sym  = 8'($urandom_range(0, 255));
        pick   = $urandom_range(0, 99);
        if (pick < 10)      r.len = 6'd0;
        else if (pick < 20) r.len = 6'($urandom_range(33, 63));
        else if (pick < 30) r.len = 6'd32;
        else if (pick < 65) r.len = 6'($urandom_range(1, 8));
        else                r.len = 6'($urandom_range(9, 31));
        if (r.len != 0) loaded.push_back(r.sym);
      end else begin
        r.kind = KindEncode;
        r.len  = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 85) r.sym = loaded[$urandom_range(0, loaded.size() - 1)];
        else                            r.sym = 8'($urandom_range(0, 255));
      end
      // every third block of 32 requests runs without gaps
      pick = $urandom_range(0, 99);
      if ((n / 32) % 3 == 0 || pick < 60) r.gap = 0;
      else if (pick < 90)                 r.gap = $urandom_range(1, 3);
      else                                r.gap = $urandom_range(8, 40);
      request_q.push_back(r);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d loads and %0d encodes, %0d packed bytes checked",
             n_loads, n_encodes, n_bytes);
    $display("with full-width, masked, saturated and unloaded codes under random stalls");
    if (n_errors == 0) begin
      $display("PASS huffman_code_bit_packer_core");
    end else begin
      $display("FAIL huffman_code_bit_packer_core");
    end
    $finish;
  end

endmodule
